@@ design/hfargb8_pkg.sv @@
// Shared types and constants for the half-float RGBA to ARGB8 converter.
package hfargb8_pkg;

    localparam int HALF_W    = 16;
    localparam int BYTE_W    = 8;
    localparam int EXP_W     = 5;
    localparam int MANT_W    = 10;
    localparam int SIG_W     = MANT_W + 1;
    localparam int SHAMT_W   = 4;
    // sig * 255 fits in sig width plus eight bits
    localparam int PROD_W    = SIG_W + BYTE_W;
    // largest shift is 14 for a value below one
    localparam int SHIFT_W   = PROD_W + 14;
    localparam int ACC_W     = SHIFT_W + 1;
    localparam int ROUND_POS = 24;
    localparam int QUOT_POS  = 25;
    localparam int QUOT_W    = ACC_W - QUOT_POS;

    localparam logic [EXP_W-1:0]  EXP_ALL_ONES = 5'h1F;
    localparam logic [EXP_W-1:0]  EXP_ONE      = 5'd15;
    localparam logic [EXP_W-1:0]  EXP_ZERO     = 5'd0;
    localparam logic [BYTE_W-1:0] UNORM_MAX    = 8'hFF;
    localparam logic [BYTE_W-1:0] UNORM_ZERO   = 8'h00;

    typedef struct packed {
        logic [HALF_W-1:0] red_half;
        logic [HALF_W-1:0] green_half;
        logic [HALF_W-1:0] blue_half;
        logic [HALF_W-1:0] alpha_half;
    } pix_in_t;

    typedef struct packed {
        logic [BYTE_W-1:0] alpha_byte;
        logic [BYTE_W-1:0] red_byte;
        logic [BYTE_W-1:0] green_byte;
        logic [BYTE_W-1:0] blue_byte;
    } pix_out_t;

endpackage

@@ design/hfargb8_chan_conv.sv @@
// One channel: binary16 bit pattern to unorm8 with round half up.
module hfargb8_chan_conv
    import hfargb8_pkg::*;
(
    input  logic [HALF_W-1:0] half_in,
    output logic [BYTE_W-1:0] byte_out
);

    logic              sign;
    logic [EXP_W-1:0]  expo;
    logic [MANT_W-1:0] mant;
    logic [SIG_W-1:0]  sig;
    logic [SHAMT_W-1:0] shamt;
    logic [PROD_W-1:0] prod;
    logic [SHIFT_W-1:0] shifted;
    logic [ACC_W-1:0]  acc;
    logic [QUOT_W-1:0] quot;
    logic [BYTE_W-1:0] scaled;

    assign sign = half_in[HALF_W-1];
    assign expo = half_in[MANT_W +: EXP_W];
    assign mant = half_in[MANT_W-1:0];

    // subnormals use an implicit zero and exponent one
    assign sig   = {(expo != EXP_ZERO), mant};
    assign shamt = (expo == EXP_ZERO) ? SHAMT_W'(1) : expo[SHAMT_W-1:0];

    // sig * 255 as (sig << 8) - sig
    assign prod    = {sig, {BYTE_W{1'b0}}} - PROD_W'(sig);
    assign shifted = SHIFT_W'(prod) << shamt;
    assign acc     = ACC_W'(shifted) + (ACC_W'(1) << ROUND_POS);
    assign quot    = acc[ACC_W-1:QUOT_POS];
    assign scaled  = (quot > QUOT_W'(UNORM_MAX)) ? UNORM_MAX : quot[BYTE_W-1:0];

    // special cases first, in order
    always_comb
    begin
        priority if (sign)
            byte_out = UNORM_ZERO;
        else if (expo == EXP_ALL_ONES)
            byte_out = (mant != '0) ? UNORM_ZERO : UNORM_MAX;
        else if (expo >= EXP_ONE)
            byte_out = UNORM_MAX;
        else if (expo == EXP_ZERO && mant == '0)
            byte_out = UNORM_ZERO;
        else
            byte_out = scaled;
    end

endmodule

@@ design/half_float_rgba_to_argb8_unit.sv @@
// Top level: input register, four channel converters, result register.
//
//  channel | signals                       | payload
//  --------+-------------------------------+----------------------------
//  input   | in_valid, in_ready, in_data   | pix_in_t (four binary16)
//  output  | out_valid, out_ready, out_data| pix_out_t (four unorm8)
//
// One pixel per cycle sustained while out_ready is held; an accepted request passes
// through the input register, then the result register, before it shows as valid.
// The conversion is one pass of logic between the two registers.
// Reset clears both valid flags; payload registers are not reset.
// A stalled output holds its result; the input stage keeps accepting
// as long as its register is empty or moving on.
module half_float_rgba_to_argb8_unit
    import hfargb8_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  pix_in_t  in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output pix_out_t out_data
);

    logic     s1_valid_reg, s1_valid_next;
    pix_in_t  s1_data_reg;
    logic     out_valid_reg, out_valid_next;
    pix_out_t out_data_reg;
    pix_out_t conv;
    logic     s1_move;
    logic     in_take;

    // stage handshake
    assign s1_move  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_move;
    assign in_take  = in_valid && in_ready;

    assign s1_valid_next  = in_take || (s1_valid_reg && !s1_move);
    assign out_valid_next = s1_move || (out_valid_reg && !out_ready);

    // channel converters
    hfargb8_chan_conv u_conv_a (.half_in(s1_data_reg.alpha_half), .byte_out(conv.alpha_byte));
    hfargb8_chan_conv u_conv_r (.half_in(s1_data_reg.red_half),   .byte_out(conv.red_byte));
    hfargb8_chan_conv u_conv_g (.half_in(s1_data_reg.green_half), .byte_out(conv.green_byte));
    hfargb8_chan_conv u_conv_b (.half_in(s1_data_reg.blue_half),  .byte_out(conv.blue_byte));

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
            s1_data_reg <= in_data;
        if (s1_move)
            out_data_reg <= conv;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // an accepted request lands in the input register
    a_take_lands: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> s1_valid_reg)
        else $error("accepted request missing from input stage");

    // a held input stage behind a stalled output is not lost or changed
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && out_valid_reg && !out_ready |=> s1_valid_reg && $stable(s1_data_reg))
        else $error("input stage lost data under stall");

    // a staged request reaches an empty output in the next cycle
    a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !out_valid_reg |=> out_valid_reg)
        else $error("staged request did not reach output");

endmodule

@@ bench/testbench.sv @@
// Self-checking bench for the half-float RGBA to ARGB8 pixel converter.
module testbench;
    import hfargb8_pkg::*;

    localparam int RANDOM_PIXELS = 800;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int REPORT_MAX    = 10;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     in_valid  = 1'b0;
    logic     in_ready;
    pix_in_t  in_data   = '0;
    logic     out_valid;
    logic     out_ready = 1'b0;
    pix_out_t out_data;

    // pixels waiting to be sent, and bytes predicted for accepted pixels
    pix_in_t  pending_pixels[$];
    pix_out_t expected_argb[$];

    int  error_count = 0;
    int  cycle_count = 0;
    bit  req_taken   = 1'b0;
    int  in_gap      = 0;
    int  in_calm     = 0;
    int  out_stall   = 0;
    int  out_calm    = 0;

    // corner patterns: zeros, one, infinities, NaNs, subnormal and normal edges
    logic [HALF_W-1:0] special_halves [0:15] = '{
        16'h0000, 16'h8000, 16'h3C00, 16'h3BFF, 16'h7C00, 16'hFC00, 16'h7E00, 16'hFE01,
        16'h0001, 16'h03FF, 16'h0400, 16'h8001, 16'h7BFF, 16'hFFFF, 16'h3800, 16'h7C01
    };

    half_float_rgba_to_argb8_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // exact binary16 to unorm8 with round half up
    function automatic logic [BYTE_W-1:0] half_to_byte(input logic [HALF_W-1:0] h);
        logic [EXP_W-1:0]  ex;
        logic [MANT_W-1:0] mt;
        logic [SIG_W-1:0]  sig;
        logic [EXP_W-1:0]  sh;
        logic [63:0]       acc;
        ex = h[HALF_W-2:MANT_W];
        mt = h[MANT_W-1:0];
        if (h[HALF_W-1])
            return UNORM_ZERO;
        if (ex == EXP_ALL_ONES)
            return (mt != '0) ? UNORM_ZERO : UNORM_MAX;
        if (ex >= EXP_ONE)
            return UNORM_MAX;
        if (ex == EXP_ZERO)
        begin
            if (mt == '0)
                return UNORM_ZERO;
            sig = {1'b0, mt};
            sh  = 5'd1;
        end
        else
        begin
            sig = {1'b1, mt};
            sh  = ex;
        end
        acc = (64'(sig) * 64'd255) << sh;
        acc = acc + (64'd1 << ROUND_POS);
        acc = acc >> QUOT_POS;
        if (acc > 64'd255)
            acc = 64'd255;
        return acc[BYTE_W-1:0];
    endfunction

    function automatic pix_out_t convert_pixel(input pix_in_t p);
        pix_out_t r;
        r.alpha_byte = half_to_byte(p.alpha_half);
        r.red_byte   = half_to_byte(p.red_half);
        r.green_byte = half_to_byte(p.green_half);
        r.blue_byte  = half_to_byte(p.blue_half);
        return r;
    endfunction

    // mostly in-range values, with overflow, negatives, raw noise and corners mixed in
    function automatic logic [HALF_W-1:0] rand_half();
        int unsigned pick;
        logic [HALF_W-1:0] h;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            h = {1'b0, 5'($urandom_range(0, 14)), 10'($urandom)};
        else if (pick < 70)
            h = {1'b0, 5'($urandom_range(15, 31)), 10'($urandom)};
        else if (pick < 80)
            h = {1'b1, 15'($urandom)};
        else if (pick < 90)
            h = 16'($urandom);
        else
            h = special_halves[$urandom_range(0, 15)];
        return h;
    endfunction

    // idle length: usually none, sometimes short, rarely long
    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    task automatic report_error(input string msg);
        error_count++;
        if (error_count <= REPORT_MAX)
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
    endtask

    task automatic check_result(input pix_out_t got);
        pix_out_t    want;
        logic [31:0] gw;
        logic [31:0] ww;
        string       chan[4] = '{"blue", "green", "red", "alpha"};
        if (expected_argb.size() == 0)
        begin
            report_error($sformatf("unexpected result %h", got));
            return;
        end
        want = expected_argb.pop_front();
        gw = got;
        ww = want;
        for (int k = 0; k < 4; k++)
            if (gw[8*k +: 8] !== ww[8*k +: 8])
                report_error($sformatf("%s_byte expected %h got %h",
                                       chan[k], ww[8*k +: 8], gw[8*k +: 8]));
    endtask

    // sample both channels at the rising edge
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("testbench: errors");
            $finish;
        end
        else
        begin
            req_taken = rst_n && in_valid && in_ready;
            if (req_taken)
                expected_argb.push_back(convert_pixel(in_data));
            if (rst_n && out_valid && out_ready)
                check_result(out_data);
        end
    end

    // request driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_calm > 0)
                in_calm--;
            else if ($urandom_range(0, 149) == 0)
                in_calm = $urandom_range(40, 200);
            if (in_valid && !req_taken)
                ;
            else if (in_gap > 0)
            begin
                in_valid <= 1'b0;
                in_gap--;
            end
            else if (pending_pixels.size() > 0)
            begin
                in_valid <= 1'b1;
                in_data  <= pending_pixels.pop_front();
                in_gap   = (in_calm > 0) ? 0 : pick_gap();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // result back-pressure
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_calm > 0)
                out_calm--;
            else if ($urandom_range(0, 149) == 0)
                out_calm = $urandom_range(40, 200);
            if (out_stall > 0)
            begin
                out_ready <= 1'b0;
                out_stall--;
            end
            else
            begin
                out_ready <= 1'b1;
                out_stall = (out_calm > 0) ? 0 : pick_gap();
            end
        end
    end

    initial
    begin
        pix_in_t p;
        // corner patterns rotated so each lands on every channel
        for (int i = 0; i < 20; i++)
        begin
            p.red_half   = special_halves[i % 16];
            p.green_half = special_halves[(i + 5) % 16];
            p.blue_half  = special_halves[(i + 9) % 16];
            p.alpha_half = special_halves[(i + 13) % 16];
            pending_pixels.push_back(p);
        end
        for (int i = 0; i < RANDOM_PIXELS; i++)
        begin
            p.red_half   = rand_half();
            p.green_half = rand_half();
            p.blue_half  = rand_half();
            p.alpha_half = rand_half();
            pending_pixels.push_back(p);
        end

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // drain: all sent, all results back, then an idle wait before the final check
        while (pending_pixels.size() != 0 || in_valid || expected_argb.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_argb.size() != 0)
            report_error($sformatf("%0d results never arrived", expected_argb.size()));

        if (error_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

@@ sim.f @@
design/hfargb8_pkg.sv
design/hfargb8_chan_conv.sv
design/half_float_rgba_to_argb8_unit.sv
bench/testbench.sv
